// ===== rtl/bas_pkg.sv =====
// shared constants, codes and control structs for the bounded array stack
package bas_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 6;
    localparam int IDX_W  = 5;
    localparam int DATA_W = 32;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int CMP_A  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CMP_W  = (CMP_A > IDX_W) ? CMP_A : IDX_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    localparam logic [KIND_W-1:0] KIND_PUSH    = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_POP     = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_DISPLAY = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_PEEK    = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_CHANGE  = KIND_W'(4);

    localparam logic [STAT_W-1:0] ST_OK       = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_OVERFLOW = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_EMPTY    = STAT_W'(2);
    localparam logic [STAT_W-1:0] ST_NOTFOUND = STAT_W'(3);

    typedef struct packed {
        logic take;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic legal;
        logic more;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/bas_ctrl.sv =====
// controller state machine: accepts an item, then sequences its results
module bas_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bas_pkg::dp_stat_t   stat,
    output bas_pkg::ctrl_cmd_t  cmd
);
    import bas_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);
    assign cmd.take = in_valid && (state_reg == S_IDLE);
    assign cmd.emit = (state_reg == S_EMIT) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                // unused kinds are swallowed with no result
                if (cmd.take && stat.legal)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (cmd.emit && !stat.more)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/bas_dp.sv =====
// datapath: entry count, capacity register, stack memory and output register
module bas_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bas_pkg::ctrl_cmd_t                   cmd,
    output bas_pkg::dp_stat_t                    stat,
    input  logic                                 cfg_valid,
    input  logic        [bas_pkg::CAP_W-1:0]     cfg_data,
    input  logic        [bas_pkg::KIND_W-1:0]    kind,
    input  logic signed [bas_pkg::DATA_W-1:0]    push_value,
    input  logic        [bas_pkg::IDX_W-1:0]     slot_index,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic        [bas_pkg::STAT_W-1:0]    status,
    output logic signed [bas_pkg::DATA_W-1:0]    read_value,
    output logic                                 last
);
    import bas_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              disp_reg, disp_next;
    logic              use_rd_reg, use_rd_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;

    logic [CMP_W-1:0]  count_ext, cap_ext, idx_ext;
    logic              full, empty, idx_bad;
    logic [ADDR_W-1:0] top_addr, idx_addr;

    assign count_ext = CMP_W'(count_reg);
    assign cap_ext   = CMP_W'(capacity_reg);
    assign idx_ext   = CMP_W'(slot_index);
    assign full      = (count_ext >= cap_ext) || (count_ext >= CMP_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign idx_bad   = (idx_ext >= count_ext) || (idx_ext >= CMP_W'(DEPTH));
    assign top_addr  = ADDR_W'(count_reg - CNT_W'(1));
    assign idx_addr  = idx_ext[ADDR_W-1:0];

    assign stat.legal    = (kind == KIND_PUSH) || (kind == KIND_POP) ||
                           (kind == KIND_DISPLAY) || (kind == KIND_PEEK) ||
                           (kind == KIND_CHANGE);
    assign stat.more     = disp_reg && (ptr_reg != '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        disp_next       = disp_reg;
        use_rd_next     = use_rd_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wa          = count_reg[ADDR_W-1:0];
        mem_ra          = top_addr;

        if (cmd.take)
        begin
            disp_next       = 1'b0;
            use_rd_next     = 1'b0;
            res_status_next = ST_OK;
            case (kind)
                KIND_PUSH:
                begin
                    if (full)
                        res_status_next = ST_OVERFLOW;
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_POP:
                begin
                    if (empty)
                        res_status_next = ST_EMPTY;
                    else
                    begin
                        mem_re      = 1'b1;
                        use_rd_next = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                KIND_DISPLAY:
                begin
                    if (empty)
                        res_status_next = ST_EMPTY;
                    else
                    begin
                        mem_re      = 1'b1;
                        use_rd_next = 1'b1;
                        disp_next   = 1'b1;
                        ptr_next    = top_addr;
                    end
                end
                KIND_PEEK:
                begin
                    if (idx_bad)
                        res_status_next = ST_NOTFOUND;
                    else
                    begin
                        mem_re      = 1'b1;
                        mem_ra      = idx_addr;
                        use_rd_next = 1'b1;
                    end
                end
                KIND_CHANGE:
                begin
                    if (idx_bad)
                        res_status_next = ST_NOTFOUND;
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wa = idx_addr;
                    end
                end
                default:
                begin
                    res_status_next = ST_OK;
                end
            endcase
        end
        else if (cmd.emit && stat.more)
        begin
            // fetch the next entry down while the current word goes out
            ptr_next = ptr_reg - ADDR_W'(1);
            mem_re   = 1'b1;
            mem_ra   = ptr_reg - ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= push_value;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            capacity_reg  <= CAP_RESET;
            disp_reg      <= 1'b0;
            use_rd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            disp_reg   <= disp_next;
            use_rd_reg <= use_rd_next;
            if (cfg_valid)
                capacity_reg <= cfg_data;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= use_rd_reg ? rd_data_reg : '0;
            out_last_reg   <= !stat.more;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign read_value = out_value_reg;
    assign last       = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && kind == KIND_PUSH && !full) |=>
            count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the stack");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && disp_reg) |-> (CNT_W'(ptr_reg) < count_reg))
        else $error("display pointer beyond live entries");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && res_status_reg != ST_OK) |=> (out_value_reg == '0))
        else $error("error result carries data");

endmodule

// ===== rtl/bounded_array_stack_core.sv =====
// top level of the bounded array stack: controller plus datapath
// A LIFO stack of up to DEPTH 32-bit words with a writable capacity (reset 32). in_ready is
// high only between items. Push, pop, peek and change each give a single word: the item is
// accepted and acted on while idle, and its word is loaded into the output register from the
// emit state once the output is free. A display of n live entries yields n words top to bottom,
// one per cycle once the output drains, paced by the registered read port of the stack memory;
// an empty display or pop gives one word with the empty status. Kinds 5 to 7 are accepted but
// give no word. Results wait in a single output register, so a stalled consumer holds the
// block in its current item. The capacity register may be written on any cycle, but only
// while no item is in flight.
module bounded_array_stack_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [bas_pkg::CAP_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic        [bas_pkg::KIND_W-1:0]    kind,
    input  logic signed [bas_pkg::DATA_W-1:0]    push_value,
    input  logic        [bas_pkg::IDX_W-1:0]     slot_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [bas_pkg::STAT_W-1:0]    status,
    output logic signed [bas_pkg::DATA_W-1:0]    read_value,
    output logic                                 last
);
    import bas_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    bas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bas_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .push_value (push_value),
        .slot_index (slot_index),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .read_value (read_value),
        .last       (last)
    );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the bounded array stack core
module tb;
    import bas_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD = 80;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_CHANGE + KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;
    localparam logic [CAP_W-1:0] PHASE_CAPS [9] = '{CAP_W'(32), CAP_W'(1), CAP_W'(0),
                                                    CAP_W'(63), CAP_W'(7), CAP_W'(32),
                                                    CAP_W'(20), CAP_W'(3), CAP_W'(32)};

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] value;
        logic              last;
    } stack_word_t;

    // shadow copy of the stack plus the words it still owes
    class stack_shadow;
        logic [DATA_W-1:0] shadow_words [DEPTH];
        int unsigned       live_count;
        logic [CAP_W-1:0]  capacity;
        stack_word_t       words_due [$];
        int                error_count;

        function new();
            live_count = 0;
            capacity = CAP_RESET;
            error_count = 0;
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function void owe(logic [STAT_W-1:0] st, logic [DATA_W-1:0] v, logic fin);
            stack_word_t w;
            w.status = st;
            w.value = v;
            w.last = fin;
            words_due.push_back(w);
        endfunction

        function void apply_op(logic [KIND_W-1:0] k, logic [DATA_W-1:0] v,
                               logic [IDX_W-1:0] idx);
            int unsigned room;
            room = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
            case (k)
                KIND_PUSH:
                    if (live_count >= room || live_count >= DEPTH)
                        owe(ST_OVERFLOW, '0, 1'b1);
                    else
                    begin
                        shadow_words[live_count] = v;
                        live_count++;
                        owe(ST_OK, '0, 1'b1);
                    end
                KIND_POP:
                    if (live_count == 0)
                        owe(ST_EMPTY, '0, 1'b1);
                    else
                    begin
                        live_count--;
                        owe(ST_OK, shadow_words[live_count], 1'b1);
                    end
                KIND_DISPLAY:
                    if (live_count == 0)
                        owe(ST_EMPTY, '0, 1'b1);
                    else
                        for (int i = live_count; i > 0; i--)
                            owe(ST_OK, shadow_words[i-1], i == 1);
                KIND_PEEK:
                    if (idx >= live_count)
                        owe(ST_NOTFOUND, '0, 1'b1);
                    else
                        owe(ST_OK, shadow_words[idx], 1'b1);
                KIND_CHANGE:
                    if (idx >= live_count)
                        owe(ST_NOTFOUND, '0, 1'b1);
                    else
                    begin
                        shadow_words[idx] = v;
                        owe(ST_OK, '0, 1'b1);
                    end
                default:
                    ; // spare kinds are dropped without a word
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            error_count++;
        endtask

        task check_word(logic [STAT_W-1:0] st, logic [DATA_W-1:0] v, logic fin);
            stack_word_t w;
            if (words_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word status %0d value %h last %b",
                                          st, v, fin));
            end
            else
            begin
                w = words_due.pop_front();
                if (st !== w.status)
                    report_mismatch($sformatf("status got %0d want %0d", st, w.status));
                if (v !== w.value)
                    report_mismatch($sformatf("read_value got %h want %h", v, w.value));
                if (fin !== w.last)
                    report_mismatch($sformatf("last got %b want %b", fin, w.last));
            end
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] push_value;
    logic [IDX_W-1:0]         slot_index;
    logic                     out_valid;
    logic                     out_ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic                     last;

    stack_shadow board;
    int          gap_odds;
    int          hold_request;
    int          cycle_count;

    bounded_array_stack_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .push_value (push_value),
        .slot_index (slot_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_value (read_value),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // results are checked before the same edge's input is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_word(status, read_value, last);
            if (in_valid && in_ready)
                board.apply_op(kind, push_value, slot_index);
        end
    end

    // output side: random stalls, plus one long hold when asked
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                out_ready = 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
                out_ready = 1'b1;
            end
            else if (gap_odds != 0 && $urandom_range(1, gap_odds * 2) == 1)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    task automatic send_item(logic [KIND_W-1:0] k, logic [DATA_W-1:0] v,
                             logic [IDX_W-1:0] idx);
        kind = k;
        push_value = v;
        slot_index = idx;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic idle_gap();
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            repeat ($urandom_range(1, 19)) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(negedge clk);
    endtask

    // capacity changes only once the block has gone quiet
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_data = cap;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_capacity(cap);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(int push_pct);
        int s;
        if ($urandom_range(0, 99) < push_pct)
            return KIND_PUSH;
        s = $urandom_range(0, 19);
        if (s < 8)
            return KIND_POP;
        if (s < 10)
            return KIND_DISPLAY;
        if (s < 14)
            return KIND_PEEK;
        if (s < 18)
            return KIND_CHANGE;
        return KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    endfunction

    task automatic run_random(int n, int push_pct);
        int               done;
        logic [KIND_W-1:0] k;
        logic [IDX_W-1:0]  idx;
        done = 0;
        while (done < n)
        begin
            k = pick_kind(push_pct);
            // mostly aim at live slots so peek and change do real work
            if (board.live_count > 0 && $urandom_range(0, 3) != 0)
                idx = IDX_W'($urandom_range(0, board.live_count - 1));
            else
                idx = IDX_W'($urandom_range(0, DEPTH - 1));
            send_item(k, pick_value(), idx);
            if (k <= KIND_CHANGE)
                done++;
            idle_gap();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_PUSH;
        push_value = '0;
        slot_index = '0;
        gap_odds = 4;
        hold_request = 0;
        cycle_count = 0;
        board = new();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty stack corners
        send_item(KIND_POP, '0, '0);
        send_item(KIND_DISPLAY, '0, '0);
        send_item(KIND_PEEK, '0, '0);
        send_item(KIND_CHANGE, 32'h1234_5678, '1);
        // value extremes, then read them back several ways
        send_item(KIND_PUSH, 32'h8000_0000, '0);
        send_item(KIND_PUSH, 32'h7fff_ffff, '0);
        send_item(KIND_PUSH, '0, '0);
        send_item(KIND_PUSH, '1, '0);
        send_item(KIND_DISPLAY, '0, '0);
        send_item(KIND_PEEK, '0, 5'd0);
        send_item(KIND_PEEK, '0, 5'd3);
        send_item(KIND_PEEK, '0, 5'd4);
        send_item(KIND_PEEK, '0, '1);
        send_item(KIND_CHANGE, 32'h5a5a_a5a5, 5'd1);
        send_item(KIND_CHANGE, 32'hdead_beef, 5'd4);
        send_item(KIND_PEEK, '0, 5'd1);
        send_item(KIND_SPARE_LO, 32'hffff_ffff, '1);
        send_item(KIND_SPARE_LO + KIND_W'(1), '0, '0);
        send_item(KIND_SPARE_HI, 32'h0bad_f00d, 5'd2);
        send_item(KIND_POP, '0, '0);
        send_item(KIND_DISPLAY, '0, '0);

        // capacity dropped below the live count
        write_capacity(CAP_W'(2));
        send_item(KIND_PUSH, pick_value(), '0);
        send_item(KIND_POP, '0, '0);
        send_item(KIND_PUSH, pick_value(), '0);
        send_item(KIND_PUSH, pick_value(), '0);
        write_capacity('0);
        send_item(KIND_PUSH, pick_value(), '0);
        send_item(KIND_POP, '0, '0);

        // capacity above the built depth: fill to the brim and dump it
        write_capacity('1);
        while (board.live_count < DEPTH)
        begin
            send_item(KIND_PUSH, pick_value(), '0);
            idle_gap();
        end
        send_item(KIND_PUSH, pick_value(), '0);
        send_item(KIND_DISPLAY, '0, '0);
        send_item(KIND_CHANGE, pick_value(), '1);
        send_item(KIND_PEEK, '0, '1);

        // long output hold while input keeps coming, then a full pause
        gap_odds = 0;
        hold_request = LONG_HOLD;
        run_random(20, 30);
        wait_drained();

        for (int p = 0; p < 9; p++)
        begin
            write_capacity(PHASE_CAPS[p]);
            gap_odds = (p == 8) ? 0 : $urandom_range(0, 3) * 2;
            run_random(30, $urandom_range(30, 65));
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (board.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/bas_pkg.sv
rtl/bas_ctrl.sv
rtl/bas_dp.sv
rtl/bounded_array_stack_core.sv
tb/tb.sv
